// File: rtl/cht_pkg.sv
// Shared constants, register indexes and controller/datapath interface types
// for the cache hit tracker. No dependencies.
`default_nettype none

package cht_pkg;

  localparam int MaxBlocks  = 64;
  localparam int EntryW     = $clog2(MaxBlocks);
  localparam int CountW     = $clog2(MaxBlocks + 1);
  localparam int AddrW      = 32;
  localparam int OffsetBits = 6;
  localparam int TagW       = AddrW - OffsetBits;
  localparam int CntW       = 32;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 7;
  localparam int CmpW       = (CountW > CfgDataW) ? CountW : CfgDataW;
  localparam int OutDataW   = ((1 + 2 * CntW + 7) / 8) * 8;
  localparam int OutPadW    = OutDataW - 1 - 2 * CntW;

  localparam logic [CfgIdxW-1:0] RegFullyAssoc = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSplit      = 2'd1;
  localparam logic [CfgIdxW-1:0] RegBlocks     = 2'd2;

  localparam logic [CfgDataW-1:0] BlocksReset = 7'd16;

  typedef struct packed {
    logic capture;
    logic dm_check;
    logic scan;
    logic pop;
    logic fill;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic fa_mode;
    logic scan_done;
    logic scan_hit;
    logic free_found;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/cht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cht_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: rtl/cht_ctrl.sv
// Controller state machine of the cache hit tracker: sequences lookup, scan,
// replacement and result. Depends on cht_pkg.
`default_nettype none

module cht_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  cht_pkg::status_t status,
  output cht_pkg::cmd_t    cmd
);

  import cht_pkg::*;

  typedef enum logic [6:0] {
    IDLE   = 7'b0000001,
    DM_RD  = 7'b0000010,
    DM_CHK = 7'b0000100,
    SCAN   = 7'b0001000,
    POP_RD = 7'b0010000,
    FILL   = 7'b0100000,
    FINISH = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    s_axis_tready = 1'b0;
    case (state)
      IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = status.fa_mode ? SCAN : DM_RD;
        end
      end
      DM_RD: begin
        state_next = DM_CHK;
      end
      DM_CHK: begin
        cmd.dm_check = 1'b1;
        state_next   = FINISH;
      end
      SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          if (status.scan_hit) begin
            state_next = FINISH;
          end else if (status.free_found) begin
            state_next = FILL;
          end else begin
            state_next = POP_RD;
          end
        end
      end
      POP_RD: begin
        cmd.pop    = 1'b1;
        state_next = FILL;
      end
      FILL: begin
        cmd.fill   = 1'b1;
        state_next = FINISH;
      end
      FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/cht_datapath.sv
// Datapath of the cache hit tracker: configuration, tag store, valid bits,
// FIFO rings, counters and output register. Depends on cht_pkg and cht_ram.
`default_nettype none

module cht_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [cht_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [cht_pkg::CfgDataW-1:0] cfg_data,
  input  logic [cht_pkg::AddrW-1:0]    s_axis_tdata,
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [cht_pkg::OutDataW-1:0] m_axis_tdata,
  input  cht_pkg::cmd_t                cmd,
  output cht_pkg::status_t             status
);

  import cht_pkg::*;

  logic                fa_mode;
  logic                split;
  logic [CfgDataW-1:0] blocks;

  logic [CmpW-1:0]     blocks_w;
  logic [CmpW-1:0]     limit_w;
  logic [CmpW-1:0]     n_w;
  logic [CountW-1:0]   n;
  logic [CountW-1:0]   n_m1;

  logic [TagW-1:0]     blk;
  logic                second;
  logic [EntryW-1:0]   base;
  logic [TagW-1:0]     mask_tag;
  logic [TagW-1:0]     dm_low;
  logic [TagW-1:0]     dm_tag;
  logic [EntryW-1:0]   dm_entry;

  logic [CountW-1:0]   issue_idx;
  logic                cmp_vld;
  logic [EntryW-1:0]   cmp_idx;
  logic [EntryW-1:0]   cmp_entry;
  logic                hit_r;
  logic                have_free;
  logic [EntryW-1:0]   free_slot;
  logic                popped;

  logic [MaxBlocks-1:0] valid;
  logic [EntryW-1:0]   head [2];
  logic [EntryW-1:0]   tail [2];
  logic [1:0]          fresh;

  logic [CntW-1:0]     access_counter;
  logic [CntW-1:0]     hit_counter;
  logic [CntW-1:0]     access_next;
  logic [CntW-1:0]     hit_next;

  logic                cur_hit;
  logic                cur_free;
  logic                cur_last;
  logic                dm_hit;
  logic                flush;

  logic [EntryW-1:0]   victim;
  logic [EntryW-1:0]   push_slot;
  logic [EntryW-1:0]   head_next;

  logic                tag_we;
  logic [EntryW-1:0]   tag_wr_addr;
  logic [TagW-1:0]     tag_wr_data;
  logic [EntryW-1:0]   tag_rd_addr;
  logic [TagW-1:0]     tag_rd;
  logic [EntryW-1:0]   ring_wr_addr;
  logic [EntryW-1:0]   ring_rd_addr;
  logic [EntryW-1:0]   ring_rd;

  // geometry in use
  always_comb begin
    blocks_w = CmpW'(blocks);
    limit_w  = split ? CmpW'(MaxBlocks / 2) : CmpW'(MaxBlocks);
    n_w      = (blocks_w == '0) ? CmpW'(1) : blocks_w;
    if (n_w > limit_w) begin
      n_w = limit_w;
    end
    n    = n_w[CountW-1:0];
    n_m1 = n - CountW'(1);
  end

  assign base     = second ? n[EntryW-1:0] : '0;
  assign mask_tag = TagW'(n_m1);
  assign dm_low   = blk & mask_tag;
  assign dm_tag   = blk & ~mask_tag;
  assign dm_entry = base + dm_low[EntryW-1:0];

  assign cmp_entry = base + cmp_idx;
  assign cur_hit   = cmp_vld & valid[cmp_entry] & (tag_rd == blk);
  assign cur_free  = cmp_vld & ~valid[cmp_entry];
  assign cur_last  = cmp_vld & (CountW'(cmp_idx) == n_m1);
  assign dm_hit    = valid[dm_entry] & (tag_rd == dm_tag);

  assign flush = cfg_we & (cfg_index == RegFullyAssoc || cfg_index == RegSplit ||
                           cfg_index == RegBlocks);

  assign victim    = popped ? ring_rd : free_slot;
  assign push_slot = (fresh[second] || (CountW'(tail[second]) == n_m1)) ?
                     '0 : tail[second] + EntryW'(1);
  assign head_next = (CountW'(head[second]) == n_m1) ? '0 : head[second] + EntryW'(1);

  assign tag_we      = (cmd.dm_check & ~dm_hit) | cmd.fill;
  assign tag_wr_addr = cmd.fill ? base + victim : dm_entry;
  assign tag_wr_data = cmd.fill ? blk : dm_tag;
  assign tag_rd_addr = cmd.scan ? base + issue_idx[EntryW-1:0] : dm_entry;

  assign ring_wr_addr = base + push_slot;
  assign ring_rd_addr = base + head[second];

  assign access_next = (access_counter == '1) ? access_counter
                                              : access_counter + CntW'(1);
  assign hit_next    = (hit_r && hit_counter != '1) ? hit_counter + CntW'(1)
                                                    : hit_counter;

  assign status.fa_mode    = fa_mode;
  assign status.scan_done  = cur_hit | cur_last;
  assign status.scan_hit   = cur_hit;
  assign status.free_found = have_free | cur_free;
  assign status.out_free   = ~m_axis_tvalid | m_axis_tready;

  cht_ram #(.Width(TagW), .Depth(MaxBlocks)) u_tag_ram (
    .clk     (clk),
    .wr_en   (tag_we),
    .wr_addr (tag_wr_addr),
    .wr_data (tag_wr_data),
    .rd_addr (tag_rd_addr),
    .rd_data (tag_rd)
  );

  cht_ram #(.Width(EntryW), .Depth(MaxBlocks)) u_ring_ram (
    .clk     (clk),
    .wr_en   (cmd.fill),
    .wr_addr (ring_wr_addr),
    .wr_data (victim),
    .rd_addr (ring_rd_addr),
    .rd_data (ring_rd)
  );

  // configuration, valid bits, ring pointers, counters
  always_ff @(posedge clk) begin
    if (rst) begin
      fa_mode        <= 1'b0;
      split          <= 1'b0;
      blocks         <= BlocksReset;
      valid          <= '0;
      head[0]        <= '0;
      head[1]        <= '0;
      tail[0]        <= '0;
      tail[1]        <= '0;
      fresh          <= 2'b11;
      access_counter <= '0;
      hit_counter    <= '0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegFullyAssoc: fa_mode <= cfg_data[0];
          RegSplit:      split   <= cfg_data[0];
          RegBlocks:     blocks  <= cfg_data;
          default: begin
          end
        endcase
      end
      if (flush) begin
        valid   <= '0;
        head[0] <= '0;
        head[1] <= '0;
        fresh   <= 2'b11;
      end else begin
        if (cmd.dm_check && !dm_hit) begin
          valid[dm_entry] <= 1'b1;
        end
        if (cmd.pop) begin
          head[second] <= head_next;
        end
        if (cmd.fill) begin
          valid[base + victim] <= 1'b1;
          tail[second]         <= push_slot;
          fresh[second]        <= 1'b0;
        end
      end
      if (cmd.finish) begin
        access_counter <= access_next;
        hit_counter    <= hit_next;
        m_axis_tvalid  <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // per-access working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld   <= 1'b0;
      hit_r     <= 1'b0;
      have_free <= 1'b0;
      popped    <= 1'b0;
      issue_idx <= '0;
    end else begin
      if (cmd.capture) begin
        cmp_vld   <= 1'b0;
        hit_r     <= 1'b0;
        have_free <= 1'b0;
        popped    <= 1'b0;
        issue_idx <= '0;
      end
      if (cmd.dm_check && dm_hit) begin
        hit_r <= 1'b1;
      end
      if (cmd.scan) begin
        if (issue_idx < n) begin
          issue_idx <= issue_idx + CountW'(1);
          cmp_vld   <= 1'b1;
        end else begin
          cmp_vld <= 1'b0;
        end
        if (cur_hit) begin
          hit_r <= 1'b1;
        end
        if (cur_free) begin
          have_free <= 1'b1;
        end
      end
      if (cmd.pop) begin
        popped <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      blk    <= s_axis_tdata[AddrW-1:OffsetBits];
      second <= split & ~s_axis_tuser;
    end
    if (cmd.scan) begin
      cmp_idx <= issue_idx[EntryW-1:0];
      if (cur_free) begin
        free_slot <= cmp_idx;
      end
    end
    if (cmd.finish) begin
      m_axis_tdata <= {{OutPadW{1'b0}}, hit_next, access_next, hit_r};
    end
  end

endmodule

`default_nettype wire

// File: rtl/cache_hit_tracker.sv
// Top level of the cache hit tracker: joins the controller and the datapath.
// Depends on cht_pkg, cht_ctrl, cht_datapath.
//
//   channel   direction  fields (lowest bit up)
//   s_axis    in         tdata: address[31:0]; tuser: is_data
//   m_axis    out        tdata: hit, access_count[31:0], hit_count[31:0], zero pad
//   cfg       in         index 0 fully_associative_mode, 1 split_caches,
//                        2 blocks_per_cache
//
// Direct mapped: an access runs IDLE, DM_RD, DM_CHK and FINISH from accept to result register.
// Fully associative: an access runs IDLE, SCAN and FINISH on a hit, with FILL before FINISH
// on a replacement and POP_RD before FILL when no entry is free; the scan reads one tag per
// cycle over the n blocks in use through the tag RAM read port.
// Reset and any write to registers 0 to 2 clear all valid bits at once; no sweep.
// A held result blocks only the next result; the next access is taken meanwhile.
`default_nettype none

module cache_hit_tracker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [cht_pkg::AddrW-1:0]    s_axis_tdata,  // address
  input  logic                         s_axis_tuser,  // is_data
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [cht_pkg::OutDataW-1:0] m_axis_tdata,  // hit, access_count, hit_count
  input  logic                         cfg_we,
  input  logic [cht_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [cht_pkg::CfgDataW-1:0] cfg_data
);

  import cht_pkg::*;

  cmd_t    cmd;
  status_t status;

  cht_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  cht_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cmd           (cmd),
    .status        (status)
  );

endmodule

`default_nettype wire

// File: tb/sv/cht_access_checker.sv
// Checker for the cache hit tracker: watches the access, result and register
// ports, predicts every result from its own tag store and compares.
// Depends on cht_pkg.

module cht_access_checker
  import cht_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [AddrW-1:0]    s_axis_tdata,  // address
  input  logic                s_axis_tuser,  // is_data
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,  // hit, access_count, hit_count, pad
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  failures,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic            hit;
    logic [CntW-1:0] accesses;
    logic [CntW-1:0] hits;
  } outcome_t;

  logic [TagW-1:0]     tags [MaxBlocks];
  bit                  valid [MaxBlocks];
  int                  ring [MaxBlocks];
  int                  head [2];
  int                  tail [2];
  logic [CntW-1:0]     access_total;
  logic [CntW-1:0]     hit_total;
  bit                  fa_mode;
  bit                  split_mode;
  logic [CfgDataW-1:0] blocks_reg;
  outcome_t            expected_outcomes [$];
  outcome_t            want;
  outcome_t            got;
  int                  fail_total = 0;

  function automatic int blocks_in_use();
    int n;
    int lim;
    n = blocks_reg;
    lim = split_mode ? MaxBlocks / 2 : MaxBlocks;
    if (n == 0) n = 1;
    if (n > lim) n = lim;
    return n;
  endfunction

  function automatic void flush_store();
    int n;
    n = blocks_in_use();
    for (int i = 0; i < MaxBlocks; i++) valid[i] = 1'b0;
    head[0] = 0;
    head[1] = 0;
    tail[0] = n - 1;
    tail[1] = n - 1;
  endfunction

  function automatic outcome_t predict_lookup(logic [AddrW-1:0] addr, logic is_data);
    int n;
    int base;
    int q;
    int e;
    int victim;
    int h;
    int free_slot;
    bit have_free;
    logic [TagW-1:0] blk;
    logic [TagW-1:0] mask;
    logic [TagW-1:0] tag;
    outcome_t res;
    n = blocks_in_use();
    q = (split_mode && !is_data) ? 1 : 0;
    base = q ? n : 0;
    blk = addr[AddrW-1:OffsetBits];
    res.hit = 1'b0;
    if (access_total != '1) access_total++;
    if (!fa_mode) begin
      mask = TagW'(n - 1);
      e = base + int'(blk & mask);
      tag = blk & ~mask;
      if (valid[e] && tags[e] == tag) begin
        res.hit = 1'b1;
      end else begin
        tags[e] = tag;
        valid[e] = 1'b1;
      end
    end else begin
      have_free = 1'b0;
      free_slot = 0;
      for (int i = 0; i < n; i++) begin
        if (valid[base + i]) begin
          if (tags[base + i] == blk) begin
            res.hit = 1'b1;
            break;
          end
        end else begin
          have_free = 1'b1;
          free_slot = i;
        end
      end
      if (!res.hit) begin
        if (have_free) begin
          victim = free_slot;
        end else begin
          h = (head[q] < n) ? head[q] : 0;
          victim = ring[base + h] % n;
          head[q] = (h >= n - 1) ? 0 : h + 1;
        end
        tags[base + victim] = blk;
        valid[base + victim] = 1'b1;
        tail[q] = (tail[q] >= n - 1) ? 0 : tail[q] + 1;
        ring[base + tail[q]] = victim;
      end
    end
    if (res.hit && hit_total != '1) hit_total++;
    res.accesses = access_total;
    res.hits = hit_total;
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fa_mode = 1'b0;
      split_mode = 1'b0;
      blocks_reg = BlocksReset;
      access_total = '0;
      hit_total = '0;
      for (int i = 0; i < MaxBlocks; i++) ring[i] = 0;
      flush_store();
      expected_outcomes.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.hit = m_axis_tdata[0];
        got.accesses = m_axis_tdata[CntW:1];
        got.hits = m_axis_tdata[2*CntW:CntW+1];
        if (expected_outcomes.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display("%0t: result with none expected: hit %0b accesses %0d hits %0d",
                     $time, got.hit, got.accesses, got.hits);
        end else begin
          want = expected_outcomes.pop_front();
          if (got.hit !== want.hit || got.accesses !== want.accesses ||
              got.hits !== want.hits) begin
            fail_total++;
            if (fail_total <= 10)
              $display("%0t: mismatch: expected hit %0b accesses %0d hits %0d, got %0b %0d %0d",
                       $time, want.hit, want.accesses, want.hits,
                       got.hit, got.accesses, got.hits);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          RegFullyAssoc: begin
            fa_mode = cfg_data[0];
            flush_store();
          end
          RegSplit: begin
            split_mode = cfg_data[0];
            flush_store();
          end
          RegBlocks: begin
            blocks_reg = cfg_data;
            flush_store();
          end
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_outcomes.push_back(predict_lookup(s_axis_tdata, s_axis_tuser));
    end
    failures <= fail_total;
    pending <= expected_outcomes.size();
  end

endmodule

// File: tb/sv/tb_cache_hit_tracker.sv
// Top of the cache hit tracker testbench: clock, reset, access and register
// stimulus, result back-pressure and the verdict.
// Depends on cht_pkg, cache_hit_tracker and cht_access_checker.

module tb_cache_hit_tracker;
  import cht_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1000000;
  localparam int LongHold   = 300;
  localparam int EndLatency = 100;
  localparam int Phases     = 16;
  localparam int PhaseItems = 80;
  localparam logic [CfgIdxW-1:0] RegBeyondList = 2'd3;

  logic                clk = 1'b0;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [AddrW-1:0]    s_axis_tdata;   // address
  logic                s_axis_tuser;   // is_data
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // hit, access_count, hit_count, pad
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  int                  failures;
  int                  pending;

  bit                  sender_calm;
  bit                  long_hold_req;
  bit                  long_hold_done;
  logic [TagW-1:0]     region [4];

  int fa_seq     [Phases] = '{0, 0, 0, 0, 0, 1, 1, 1, 1, 0, 1, 0, 0, 1, 1, 0};
  int split_seq  [Phases] = '{0, 0, 0, 1, 1, 0, 0, 1, 1, 0, 0, 1, 0, 1, 0, 1};
  int blocks_seq [Phases] = '{16, 1, 64, 32, 8, 4, 64, 32, 2, 0, 127, 127, 12, 7, 1, 5};

  cache_hit_tracker uut (.*);
  cht_access_checker checker_i (.*);

  always #2 clk = ~clk;

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [AddrW-1:0] pick_address(int n_eff);
    int r;
    int sel;
    logic [TagW-1:0] blk;
    r = $urandom_range(0, 99);
    sel = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (r < 10) blk = TagW'($urandom());
    else if (r < 30) blk = region[2] + TagW'(n_eff * $urandom_range(0, 3));
    else blk = region[sel] + TagW'($urandom_range(0, n_eff + n_eff / 2 + 1));
    return {blk, OffsetBits'($urandom_range(0, 63))};
  endfunction

  task automatic offer(input logic [AddrW-1:0] addr, input logic is_data);
    int gap;
    gap = pick_gap(sender_calm);
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= addr;
    s_axis_tuser <= is_data;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input bit fa, input bit split, input logic [CfgDataW-1:0] blocks);
    drain_results();
    write_reg(RegFullyAssoc, {6'($urandom()), fa});
    write_reg(RegSplit, {6'($urandom()), split});
    write_reg(RegBlocks, blocks);
  endtask

  // Hold off results at random; once on request, stall for a long stretch.
  initial begin : result_sink
    int idle_left;
    int cyc;
    idle_left = 0;
    cyc = 0;
    long_hold_done = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        idle_left = LongHold;
      end
      if (idle_left > 0) begin
        idle_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ((cyc / 700) % 3 != 0 && $urandom_range(0, 3) == 0) idle_left = pick_gap(1'b0);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int eff;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cfg_we = 1'b0;
    cfg_index = RegFullyAssoc;
    cfg_data = '0;
    sender_calm = 1'b0;
    long_hold_req = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // direct mapped, unified, sixteen blocks out of reset
    offer(32'h0000_0000, 1'b0);
    offer(32'h0000_003F, 1'b0);
    offer(32'hFFFF_FFFF, 1'b1);
    offer(32'hFFFF_FFC0, 1'b0);
    offer(32'h0000_0400, 1'b1);
    offer(32'h0000_0000, 1'b0);
    offer(32'h0000_0400, 1'b0);
    offer(32'h5555_5555, 1'b1);
    offer(32'hAAAA_AAAA, 1'b0);
    offer(32'hAAAA_AAAA, 1'b1);
    // a write beyond the register list must leave the store intact
    drain_results();
    write_reg(RegBeyondList, 7'h7F);
    offer(32'hAAAA_AAAA, 1'b0);

    // two-entry fully associative store: fill, hit, then replace oldest first
    configure(1'b1, 1'b0, 7'd2);
    offer(32'h0000_0040, 1'b1);
    offer(32'h0000_0080, 1'b0);
    offer(32'h0000_0040, 1'b1);
    offer(32'h0000_00C0, 1'b1);
    offer(32'h0000_0040, 1'b0);
    offer(32'h0000_0080, 1'b1);

    // split halves keep instruction and data blocks apart
    configure(1'b1, 1'b1, 7'd2);
    offer(32'h0000_1000, 1'b0);
    offer(32'h0000_1000, 1'b1);
    offer(32'h0000_1010, 1'b0);
    offer(32'h0000_1020, 1'b1);

    for (int p = 0; p < Phases; p++) begin
      configure(fa_seq[p][0], split_seq[p][0], CfgDataW'(blocks_seq[p]));
      eff = (blocks_seq[p] == 0) ? 1 : blocks_seq[p];
      if (split_seq[p] != 0 && eff > MaxBlocks / 2) eff = MaxBlocks / 2;
      if (eff > MaxBlocks) eff = MaxBlocks;
      region[0] = TagW'($urandom());
      region[1] = '1 - TagW'(eff);
      region[2] = TagW'($urandom());
      region[3] = '0;
      sender_calm = (p % 4 == 3);
      if (p == 1) long_hold_req = 1'b1;
      for (int k = 0; k < PhaseItems; k++) begin
        if (k == PhaseItems / 2 && p % 5 == 2) drain_results();
        offer(pick_address(eff), 1'($urandom_range(0, 1)));
      end
    end

    drain_results();
    repeat (EndLatency) @(posedge clk);
    if (failures == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
